>>> rtl/ltbl_pkg.sv
// Line-table lookup package: field widths, operation codes, controller states
// and the command/status structs between controller and datapath.
// No dependencies.
package ltbl_pkg;

  localparam int TABLE_DEPTH_DEF = 256;
  localparam int CFG_W   = 9;
  localparam int IDX_W   = 8;
  localparam int OFS_W   = 16;
  localparam int LINE_W  = 24;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  typedef enum logic [6:0] {
    ST_IDLE    = 7'b0000001,
    ST_CHECK   = 7'b0000010,
    ST_EVAL    = 7'b0000100,
    ST_WALK_RD = 7'b0001000,
    ST_WALK_EV = 7'b0010000,
    ST_LINE_RD = 7'b0100000,
    ST_DONE    = 7'b1000000
  } state_t;

  typedef struct packed {
    logic write;     // store the entry on the input ports
    logic init;      // load query and search bounds
    logic probe;     // read entries mid and mid+1, latch mid
    logic upd_high;  // high = mid - 1
    logic upd_low;   // low = mid + 1
    logic walk_dec;  // mid = mid - 1
  } cmd_t;

  typedef struct packed {
    logic search_open;  // low <= high
    logic probe_gt;     // offset[mid] > query
    logic probe_lt;     // offset[mid] < query
    logic stop_next;    // mid < n-1 and offset[mid+1] >= query
    logic walk_more;    // mid > 0 and offset[mid] >= query
  } status_t;

endpackage

>>> rtl/ltbl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ltbl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/ltbl_ctrl.sv
// Line-table lookup controller: issues table writes and sequences the binary
// search, backward walk and line read. Depends on ltbl_pkg.
module ltbl_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             in_operation,
  input  ltbl_pkg::status_t sts,
  output ltbl_pkg::cmd_t   cmd,
  output logic             busy,
  output logic             out_valid
);
  import ltbl_pkg::*;

  state_t state_r, state_nxt;
  logic   accept;

  assign accept = start && (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && in_operation == OP_LOOKUP) begin
          cmd.init  = 1'b1;
          state_nxt = ST_CHECK;
        end else if (accept) begin
          cmd.write = 1'b1;
        end
      end
      ST_CHECK: begin
        if (sts.search_open) begin
          cmd.probe = 1'b1;
          state_nxt = ST_EVAL;
        end else begin
          state_nxt = ST_WALK_RD;
        end
      end
      ST_EVAL: begin
        if (sts.probe_gt) begin
          cmd.upd_high = 1'b1;
          state_nxt    = ST_CHECK;
        end else if (sts.probe_lt && !sts.stop_next) begin
          cmd.upd_low = 1'b1;
          state_nxt   = ST_CHECK;
        end else begin
          state_nxt = ST_WALK_RD;
        end
      end
      ST_WALK_RD: state_nxt = ST_WALK_EV;
      ST_WALK_EV: begin
        if (sts.walk_more) begin
          cmd.walk_dec = 1'b1;
          state_nxt    = ST_WALK_RD;
        end else begin
          state_nxt = ST_LINE_RD;
        end
      end
      ST_LINE_RD: state_nxt = ST_DONE;
      ST_DONE:    state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_DONE);

  a_lookup_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_operation == OP_LOOKUP) |=> busy)
    else $error("lookup accepted but block not busy");

  a_write_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_operation == OP_WRITE) |=> !busy)
    else $error("write beat left the block busy");

  a_result_ends_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy && !out_valid)
    else $error("result strobe not followed by idle");

  a_single_command: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("more than one datapath command at once");

endmodule

>>> rtl/ltbl_dp.sv
// Line-table lookup datapath: count register, search bounds, query register
// and the offset/line RAMs. Depends on ltbl_pkg and ltbl_ram.
module ltbl_dp #(
  parameter int TABLE_DEPTH = ltbl_pkg::TABLE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ltbl_pkg::cmd_t              cmd,
  output ltbl_pkg::status_t           sts,
  input  logic                        cfg_we,
  input  logic [ltbl_pkg::CFG_W-1:0]  cfg_entry_count,
  input  logic [ltbl_pkg::IDX_W-1:0]  in_entry_index,
  input  logic [ltbl_pkg::OFS_W-1:0]  in_entry_offset,
  input  logic [ltbl_pkg::LINE_W-1:0] in_entry_line,
  input  logic [ltbl_pkg::OFS_W-1:0]  in_query_offset,
  output logic [ltbl_pkg::LINE_W-1:0] out_line_number
);
  import ltbl_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int IW = AW + 2;                       // signed bound width
  localparam int EW = (AW + 1 > CFG_W) ? AW + 1 : CFG_W;
  localparam int MW = IDX_W + AW;

  logic [CFG_W-1:0]     entry_count_r;
  logic [AW-1:0]        nm1_r;
  logic [OFS_W-1:0]     query_r;
  logic signed [IW-1:0] low_r, high_r;
  logic [AW-1:0]        mid_r;

  logic [EW-1:0]        cnt_e;
  logic [AW-1:0]        nm1_nxt;
  logic signed [IW-1:0] mid_calc;
  logic [AW-1:0]        mid_addr;
  logic [AW-1:0]        rd_addr_a, rd_addr_b;
  logic [AW-1:0]        slot;
  logic [OFS_W-1:0]     ofs_a, ofs_b;

  // Clamp the count to [1, TABLE_DEPTH] and keep n-1.
  always_comb begin
    cnt_e = EW'(entry_count_r);
    if (cnt_e == '0) begin
      nm1_nxt = '0;
    end else if (cnt_e > EW'(TABLE_DEPTH)) begin
      nm1_nxt = AW'(TABLE_DEPTH - 1);
    end else begin
      nm1_nxt = AW'(cnt_e - EW'(1));
    end
  end

  // Slot wraps modulo the depth.
  generate
    if (TABLE_DEPTH >= (1 << IDX_W)) begin : g_slot_wide
      assign slot = AW'(in_entry_index);
    end else begin : g_slot_mod
      logic [MW-1:0] rem;
      always_comb begin
        rem = MW'(in_entry_index);
        for (int k = IDX_W - 1; k >= 0; k--) begin
          if (rem >= (MW'(TABLE_DEPTH) << k)) begin
            rem = rem - (MW'(TABLE_DEPTH) << k);
          end
        end
      end
      assign slot = rem[AW-1:0];
    end
  endgenerate

  assign mid_calc  = low_r + ((high_r - low_r) >>> 1);
  assign mid_addr  = mid_calc[AW-1:0];
  assign rd_addr_a = cmd.probe ? mid_addr : mid_r;
  assign rd_addr_b = mid_addr + AW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= CFG_W'(1);
    end else if (cfg_we) begin
      entry_count_r <= cfg_entry_count;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      query_r <= in_query_offset;
      nm1_r   <= nm1_nxt;
      low_r   <= '0;
      high_r  <= $signed({2'b00, nm1_nxt});
      mid_r   <= '0;
    end
    if (cmd.probe) begin
      mid_r <= mid_addr;
    end
    if (cmd.upd_high) begin
      high_r <= $signed({2'b00, mid_r}) - IW'(1);
    end
    if (cmd.upd_low) begin
      low_r <= $signed({2'b00, mid_r}) + IW'(1);
    end
    if (cmd.walk_dec) begin
      mid_r <= mid_r - AW'(1);
    end
  end

  ltbl_ram #(.WIDTH(OFS_W), .DEPTH(TABLE_DEPTH)) u_ofs_a (
    .clk(clk), .we(cmd.write), .waddr(slot), .wdata(in_entry_offset),
    .raddr(rd_addr_a), .rdata(ofs_a)
  );

  ltbl_ram #(.WIDTH(OFS_W), .DEPTH(TABLE_DEPTH)) u_ofs_b (
    .clk(clk), .we(cmd.write), .waddr(slot), .wdata(in_entry_offset),
    .raddr(rd_addr_b), .rdata(ofs_b)
  );

  ltbl_ram #(.WIDTH(LINE_W), .DEPTH(TABLE_DEPTH)) u_line (
    .clk(clk), .we(cmd.write), .waddr(slot), .wdata(in_entry_line),
    .raddr(mid_r), .rdata(out_line_number)
  );

  assign sts.search_open = (low_r <= high_r);
  assign sts.probe_gt    = (ofs_a > query_r);
  assign sts.probe_lt    = (ofs_a < query_r);
  assign sts.stop_next   = (mid_r < nm1_r) && (ofs_b >= query_r);
  assign sts.walk_more   = (mid_r != '0) && (ofs_a >= query_r);

  a_probe_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.probe |-> (mid_calc >= low_r) && (mid_calc <= high_r))
    else $error("probe outside search bounds");

  a_probe_below_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.probe |-> (mid_addr <= nm1_r))
    else $error("probe beyond valid entries");

  a_walk_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.walk_dec |-> (mid_r != '0))
    else $error("backward walk below entry 0");

endmodule

>>> rtl/line_table_binary_lookup_top.sv
// Top level of the line-table lookup block: controller plus datapath.
// Depends on ltbl_pkg, ltbl_ctrl, ltbl_dp (and ltbl_ram below it).
//
// Usage:
//   Input channel: a beat is taken at a rising edge with start high and busy
//   low. in_operation selects a table write or a lookup. A write stores
//   (in_entry_offset, in_entry_line) at slot in_entry_index modulo
//   TABLE_DEPTH in the same edge and leaves the block idle, so writes can
//   follow each other every cycle.
//   A lookup raises busy and runs a binary floor search over the first
//   entry_count entries, then a backward walk, then reads the line RAM.
//   Each search probe sets the RAM addresses in ST_CHECK and compares the
//   registered RAM data in ST_EVAL; each backward step likewise reads in
//   ST_WALK_RD and compares in ST_WALK_EV, then ST_LINE_RD reads the line
//   RAM and ST_DONE gives the result. Busy drops the cycle after the
//   result, so the next lookup can be taken once busy is low.
//   Result channel: out_valid is high for exactly one cycle with
//   out_line_number; the receiver cannot hold it off.
//   Configuration: cfg_we writes cfg_entry_count (0 acts as 1, values above
//   TABLE_DEPTH saturate); write it only while idle.
//   Reset (rst_n low, synchronous) returns the controller to idle and sets
//   entry_count to 1. Table contents are not cleared: read only entries
//   that have been written.
module line_table_binary_lookup_top #(
  parameter int TABLE_DEPTH = ltbl_pkg::TABLE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_operation,
  input  logic [ltbl_pkg::IDX_W-1:0]  in_entry_index,
  input  logic [ltbl_pkg::OFS_W-1:0]  in_entry_offset,
  input  logic [ltbl_pkg::LINE_W-1:0] in_entry_line,
  input  logic [ltbl_pkg::OFS_W-1:0]  in_query_offset,
  output logic                        out_valid,
  output logic [ltbl_pkg::LINE_W-1:0] out_line_number,
  input  logic                        cfg_we,
  input  logic [ltbl_pkg::CFG_W-1:0]  cfg_entry_count
);
  import ltbl_pkg::*;

  cmd_t    cmd;
  status_t sts;

  // Controller: owns the handshake and steps the search.
  ltbl_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .in_operation(in_operation),
    .sts         (sts),
    .cmd         (cmd),
    .busy        (busy),
    .out_valid   (out_valid)
  );

  // Datapath: bounds, compares and the table RAMs.
  ltbl_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_we         (cfg_we),
    .cfg_entry_count(cfg_entry_count),
    .in_entry_index (in_entry_index),
    .in_entry_offset(in_entry_offset),
    .in_entry_line  (in_entry_line),
    .in_query_offset(in_query_offset),
    .out_line_number(out_line_number)
  );

endmodule
